// File: hw/rtl/urhps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package urhps_pkg;

  // Default number of downstream ports (legal range 1 to 8).
  localparam int unsigned PORTS_DEF = 8;

  // Width of the change bitmap reported on a poll.
  localparam int unsigned BITMAP_W = 9;

  // Port status word bits (status in the low half, change bits in the high half).
  localparam logic [31:0] ST_CONNECT = 32'h0000_0001;
  localparam logic [31:0] ST_ENABLE  = 32'h0000_0002;
  localparam logic [31:0] ST_RESET   = 32'h0000_0010;
  localparam logic [31:0] ST_LOW     = 32'h0000_0200;
  localparam logic [31:0] ST_HIGH    = 32'h0000_0400;
  localparam logic [31:0] CH_CONNECT = 32'h0001_0000;
  localparam logic [31:0] CH_RESET   = 32'h0010_0000;
  localparam logic [31:0] CH_MASK    = 32'h001F_0000;

  // Feature selectors that get special handling.
  localparam logic [4:0] SEL_SUSPEND = 5'd2;
  localparam logic [4:0] SEL_RESET   = 5'd4;
  localparam logic [4:0] SEL_C_RESET = 5'd20;

  typedef enum logic [1:0] {
    CMD_ATTACH  = 2'd0,
    CMD_DETACH  = 2'd1,
    CMD_REQUEST = 2'd2,
    CMD_POLL    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REQ_CLR_HUB_FEAT  = 3'd0,
    REQ_CLR_PORT_FEAT = 3'd1,
    REQ_GET_HUB_DESC  = 3'd2,
    REQ_GET_HUB_STAT  = 3'd3,
    REQ_GET_PORT_STAT = 3'd4,
    REQ_SET_HUB_FEAT  = 3'd5,
    REQ_SET_PORT_FEAT = 3'd6
  } req_kind_e;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_NO_FREE = 3'd1,
    ERR_NOT_ACC = 3'd2,
    ERR_INVALID = 3'd3,
    ERR_STALL   = 3'd4
  } err_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new item and clear the working result
    logic step;      // evaluate and update the currently addressed port
    logic idx_inc;   // move the port walk to the next port
    logic out_load;  // copy the working result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;   // command of the item in work
    logic hit;   // current port is the one an attach or detach looks for
    logic last;  // current port is the highest one
  } dp_stat_t;

  // Speed code to status word speed bit: low is bit 9, high is bit 10.
  function automatic logic [31:0] speed_bits(input logic [1:0] spd);
    logic [31:0] r;
    r = '0;
    if (spd == 2'd3) begin
      r = ST_HIGH;
    end else if (spd == 2'd1) begin
      r = ST_LOW;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/urhps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module urhps_ctrl
  import urhps_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output dp_cmd_t       cmd_o,
  input  wire dp_stat_t stat_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WORK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WORK;
        end
      end
      S_WORK: begin
        cmd_o.step = 1'b1;
        // A request touches one port; a walk ends on a match or at the last port.
        if (stat_i.cmd == CMD_REQUEST || stat_i.hit || stat_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/urhps_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module urhps_dp
  import urhps_pkg::*;
#(
  parameter int unsigned PORTS = PORTS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_data_i,
  input  wire logic [1:0]    command_i,
  input  wire logic [15:0]   device_id_i,
  input  wire logic [1:0]    speed_i,
  input  wire logic [2:0]    request_kind_i,
  input  wire logic [4:0]    feature_i,
  input  wire logic [7:0]    port_number_i,
  input  wire dp_cmd_t       cmd_i,
  output dp_stat_t           stat_o,
  output logic [2:0]         error_o,
  output logic [31:0]        port_status_word_o,
  output logic [BITMAP_W-1:0] change_bitmap_o,
  output logic [1:0]         bitmap_length_o
);

  localparam int unsigned IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam logic [1:0]  LEN   = 2'(1 + PORTS / 8);

  logic              acc_q;
  cmd_e              cmd_q;
  logic [15:0]       dev_q;
  logic [1:0]        spd_q;
  req_kind_e         kind_q;
  logic [4:0]        feat_q;
  logic [7:0]        pnum_q;
  logic [IDX_W-1:0]  idx_q;
  err_e              err_q;
  logic [31:0]       word_q;
  logic [BITMAP_W-1:0] bitmap_q;

  logic [2:0]          out_err_q;
  logic [31:0]         out_word_q;
  logic [BITMAP_W-1:0] out_bitmap_q;
  logic [1:0]          out_len_q;

  logic [31:0] status_q [PORTS];
  logic        in_use_q [PORTS];
  logic [1:0]  speed_q  [PORTS];
  logic [15:0] device_q [PORTS];

  logic [7:0]       pm1;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      cur_st, nxt_st, tmp_st, feat_bit;
  logic             cur_use;
  logic [1:0]       cur_spd;
  logic [15:0]      cur_dev;
  logic             hit;
  err_e             req_err;
  logic             req_op;
  logic             wr_en;
  logic [IDX_W:0]   bit_pos;

  assign pm1    = pnum_q - 8'd1;
  assign rd_idx = (cmd_q == CMD_REQUEST) ? pm1[IDX_W-1:0] : idx_q;

  assign cur_st  = status_q[rd_idx];
  assign cur_use = in_use_q[rd_idx];
  assign cur_spd = speed_q[rd_idx];
  assign cur_dev = device_q[rd_idx];

  assign hit = ((cmd_q == CMD_ATTACH) && !cur_use) ||
               ((cmd_q == CMD_DETACH) && cur_use && (cur_dev == dev_q));

  assign feat_bit = 32'd1 << feat_q;
  assign bit_pos  = (IDX_W + 1)'(idx_q) + (IDX_W + 1)'(1);

  // Hub request screening; only port requests on a valid port touch state.
  always_comb begin
    req_err = ERR_OK;
    req_op  = 1'b0;
    if (!acc_q) begin
      req_err = ERR_NOT_ACC;
    end else if (pnum_q > 8'(PORTS)) begin
      req_err = ERR_INVALID;
    end else if (kind_q == REQ_SET_HUB_FEAT) begin
      req_err = ERR_STALL;
    end else if (kind_q inside {REQ_CLR_PORT_FEAT, REQ_GET_PORT_STAT, REQ_SET_PORT_FEAT}) begin
      if (pnum_q == 8'd0) begin
        req_err = ERR_STALL;
      end else begin
        req_op = 1'b1;
      end
    end
  end

  // Next status word of the addressed port.
  always_comb begin
    tmp_st = cur_st;
    nxt_st = cur_st;
    wr_en  = 1'b0;
    case (cmd_q)
      CMD_ATTACH: begin
        nxt_st = cur_st | speed_bits(spd_q) | ST_CONNECT | CH_CONNECT;
        wr_en  = cmd_i.step && hit;
      end
      CMD_DETACH: begin
        nxt_st = (cur_st & ~ST_CONNECT) | CH_CONNECT;
        wr_en  = cmd_i.step && hit;
      end
      CMD_REQUEST: begin
        wr_en = cmd_i.step && req_op;
        case (kind_q)
          REQ_CLR_PORT_FEAT: begin
            if (feat_q != SEL_SUSPEND) begin
              if (feat_q == SEL_C_RESET) begin
                tmp_st = cur_st | speed_bits(cur_spd);
              end
              nxt_st = tmp_st & ~feat_bit;
            end
          end
          REQ_SET_PORT_FEAT: begin
            if (feat_q != SEL_SUSPEND) begin
              if (feat_q == SEL_RESET && (cur_st & ST_ENABLE) != '0) begin
                tmp_st = cur_st & ~(ST_ENABLE | ST_LOW | ST_HIGH);
              end
              nxt_st = tmp_st | feat_bit;
            end
          end
          REQ_GET_PORT_STAT: begin
            // Reading a port in reset completes the reset.
            if ((cur_st & ST_RESET) != '0) begin
              nxt_st = (cur_st | CH_RESET | ST_ENABLE) & ~ST_RESET;
            end
          end
          default: begin
            nxt_st = cur_st;
          end
        endcase
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORTS; i++) begin
        status_q[i] <= '0;
        in_use_q[i] <= 1'b0;
        speed_q[i]  <= '0;
      end
    end else if (wr_en) begin
      status_q[rd_idx] <= nxt_st;
      if (cmd_q == CMD_ATTACH) begin
        in_use_q[rd_idx] <= 1'b1;
        speed_q[rd_idx]  <= spd_q;
      end else if (cmd_q == CMD_DETACH) begin
        in_use_q[rd_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && cmd_q == CMD_ATTACH) begin
      device_q[rd_idx] <= dev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b1;
    end else if (cfg_we_i) begin
      acc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_ATTACH;
      idx_q <= '0;
    end else if (cmd_i.load) begin
      cmd_q <= cmd_e'(command_i);
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dev_q    <= device_id_i;
      spd_q    <= speed_i;
      kind_q   <= req_kind_e'(request_kind_i);
      feat_q   <= feature_i;
      pnum_q   <= port_number_i;
      err_q    <= (cmd_e'(command_i) == CMD_ATTACH) ? ERR_NO_FREE : ERR_OK;
      word_q   <= '0;
      bitmap_q <= '0;
    end else if (cmd_i.step) begin
      case (cmd_q)
        CMD_ATTACH: begin
          if (hit) begin
            err_q <= ERR_OK;
          end
        end
        CMD_REQUEST: begin
          err_q <= req_err;
          if (req_op && kind_q == REQ_GET_PORT_STAT) begin
            word_q <= nxt_st;
          end
        end
        CMD_POLL: begin
          if (acc_q && (cur_st & CH_MASK) != '0) begin
            bitmap_q <= bitmap_q | (BITMAP_W'(1) << bit_pos);
          end
        end
        default: begin
          err_q <= err_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_err_q    <= err_q;
      out_word_q   <= word_q;
      out_bitmap_q <= bitmap_q;
      out_len_q    <= (bitmap_q != '0) ? LEN : 2'd0;
    end
  end

  assign stat_o.cmd  = cmd_q;
  assign stat_o.hit  = hit;
  assign stat_o.last = (idx_q == IDX_W'(PORTS - 1));

  assign error_o            = out_err_q;
  assign port_status_word_o = out_word_q;
  assign change_bitmap_o    = out_bitmap_q;
  assign bitmap_length_o    = out_len_q;

endmodule

`default_nettype wire

// File: hw/rtl/usb_root_hub_port_status.sv
// Sequence: a hub request is captured, applied to its one port and handed to the output
//   register; attach, detach and poll instead walk the ports one per cycle.
// A new beat is taken only after the previous one has passed through capture,
//   the port walk and the hand-off; a stalled result holds input off.
// Reset (rst_ni, asynchronous, active low) clears all port status, in-use and speed
//   entries at once and sets hw_accessible; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module usb_root_hub_port_status
  import urhps_pkg::*;
#(
  parameter int unsigned PORTS = PORTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel: bit 0 of the data is hw_accessible.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  // Item input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: device_id[15:0], speed[17:16], feature[22:18], port_number[30:23], zero[31]
  input  wire logic [31:0] s_axis_tdata,
  // tuser: command[1:0], request_kind[4:2]
  input  wire logic [4:0]  s_axis_tuser,
  // Result output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: error[2:0], port_status_word[34:3], change_bitmap[43:35],
  //        bitmap_length[45:44], zero[47:46]
  output logic [47:0]      m_axis_tdata
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic [2:0]          error;
  logic [31:0]         port_status_word;
  logic [BITMAP_W-1:0] change_bitmap;
  logic [1:0]          bitmap_length;

  // The register may be written at any time the block is idle, so the channel never stalls.
  assign cfg_ready_o = 1'b1;

  // The controller sequences each item: capture, a port walk or a single port
  // update, then a hand-off into the output register. The output register lets
  // the next beat be taken while the previous result still waits downstream.
  urhps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  // The datapath holds the per-port tables, the captured item and the result.
  urhps_dp #(
    .PORTS(PORTS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid_i),
    .cfg_data_i         (cfg_data_i),
    .command_i          (s_axis_tuser[1:0]),
    .device_id_i        (s_axis_tdata[15:0]),
    .speed_i            (s_axis_tdata[17:16]),
    .request_kind_i     (s_axis_tuser[4:2]),
    .feature_i          (s_axis_tdata[22:18]),
    .port_number_i      (s_axis_tdata[30:23]),
    .cmd_i              (dp_cmd),
    .stat_o             (dp_stat),
    .error_o            (error),
    .port_status_word_o (port_status_word),
    .change_bitmap_o    (change_bitmap),
    .bitmap_length_o    (bitmap_length)
  );

  assign m_axis_tdata = {2'b00, bitmap_length, change_bitmap, port_status_word, error};

  // The block works on one item at a time: after a beat is taken, the input
  // side must close until the result has been handed to the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is still in work");

  // A new result only appears after the controller has been busy with an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result presented without an item in work");

  // The reported bitmap length tracks whether any change bit was found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((bitmap_length != 2'd0) == (change_bitmap != '0)))
    else $error("bitmap length disagrees with change bitmap");

endmodule

`default_nettype wire
